FILE: design/frc_pkg.sv
package frc_pkg;

  // Frame layout
  localparam logic [7:0] START_BYTE   = 8'h02;
  localparam logic [7:0] LENGTH_BYTE  = 8'h0E;
  localparam logic [3:0] READ_CODE    = 4'h1;
  localparam logic [7:0] ADDR_OFFSET  = 8'd128;
  localparam logic [3:0] HDR_LAST_POS = 4'd6;
  localparam logic [3:0] VAL_LAST_POS = 4'd10;
  localparam logic [3:0] STS_LAST_POS = 4'd12;
  localparam logic [3:0] CSUM_POS     = 4'd15;

  localparam int unsigned ADDR_W = 6;
  localparam int unsigned PNUM_W = 12;
  localparam int unsigned CFG_W  = 12;

  // Configuration register indexes
  typedef enum logic {
    CFG_DEV_ADDR  = 1'b0,
    CFG_PARAM_NUM = 1'b1
  } frc_cfg_e;

  // Frame error codes
  typedef enum logic [1:0] {
    FRC_OK   = 2'd0,
    FRC_CSUM = 2'd1,
    FRC_HDR  = 2'd2
  } frc_err_e;

  typedef struct packed {
    logic [1:0]  frame_error;
    logic [31:0] param_value;
    logic [15:0] stat_word;
  } frc_result_t;

  // Expected request header byte at a given frame position
  function automatic logic [7:0] exp_hdr_byte(input logic [3:0]        pos,
                                              input logic [ADDR_W-1:0] addr,
                                              input logic [PNUM_W-1:0] pnum);
    logic [7:0] b;
    case (pos)
      4'd0:    b = START_BYTE;
      4'd1:    b = LENGTH_BYTE;
      4'd2:    b = {2'b00, addr} + ADDR_OFFSET;
      4'd3:    b = {READ_CODE, pnum[11:8]};
      4'd4:    b = pnum[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: design/frc_if.sv
// Byte stream into the checker
interface frc_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Checked frame results out of the checker
interface frc_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  frame_error;
  logic [31:0] param_value;
  logic [15:0] stat_word;

  modport source (output valid, output frame_error, output param_value,
                  output stat_word, input ready);
  modport sink   (input valid, input frame_error, input param_value,
                  input stat_word, output ready);
endinterface

FILE: design/frc_tracker.sv
module frc_tracker
  import frc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        rx_byte_i,
  input  logic [ADDR_W-1:0] dev_addr_i,
  input  logic [PNUM_W-1:0] param_num_i,
  output logic              res_valid_o,
  output frc_result_t       result_o
);

  logic        collecting_q, collecting_d;
  logic [3:0]  idx_q, idx_d;
  logic [7:0]  xor_q, xor_d;
  logic        hdr_ok_q, hdr_ok_d;
  logic [31:0] val_q, val_d;
  logic [15:0] sts_q, sts_d;

  logic active;
  logic last_word;

  // Hunting state already holds the cleared frame values, so use it directly
  assign active    = collecting_q || (rx_byte_i == START_BYTE);
  assign last_word = collecting_q && (idx_q == CSUM_POS);

  assign res_valid_o = accept_i && last_word;

  // Build the result from the checksum word
  always_comb begin
    result_o = '0;
    if (rx_byte_i != xor_q) begin
      result_o.frame_error = FRC_CSUM;
    end else if (!hdr_ok_q) begin
      result_o.frame_error = FRC_HDR;
    end else begin
      result_o.frame_error = FRC_OK;
      result_o.param_value = val_q;
      result_o.stat_word   = sts_q;
    end
  end

  // Advance frame state on each accepted word
  always_comb begin
    collecting_d = collecting_q;
    idx_d        = idx_q;
    xor_d        = xor_q;
    hdr_ok_d     = hdr_ok_q;
    val_d        = val_q;
    sts_d        = sts_q;
    if (accept_i && active) begin
      if (last_word) begin
        collecting_d = 1'b0;
        idx_d        = '0;
        xor_d        = '0;
        hdr_ok_d     = 1'b1;
        val_d        = '0;
        sts_d        = '0;
      end else begin
        collecting_d = 1'b1;
        idx_d        = idx_q + 4'd1;
        xor_d        = xor_q ^ rx_byte_i;
        if (idx_q <= HDR_LAST_POS) begin
          if (rx_byte_i != exp_hdr_byte(idx_q, dev_addr_i, param_num_i)) begin
            hdr_ok_d = 1'b0;
          end
        end else if (idx_q <= VAL_LAST_POS) begin
          // shift in nonzero value bytes only
          if (rx_byte_i != 8'h00) begin
            val_d = {val_q[23:0], rx_byte_i};
          end
        end else if (idx_q <= STS_LAST_POS) begin
          sts_d = {sts_q[7:0], rx_byte_i};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collecting_q <= 1'b0;
      idx_q        <= '0;
      xor_q        <= '0;
      hdr_ok_q     <= 1'b1;
      val_q        <= '0;
      sts_q        <= '0;
    end else begin
      collecting_q <= collecting_d;
      idx_q        <= idx_d;
      xor_q        <= xor_d;
      hdr_ok_q     <= hdr_ok_d;
      val_q        <= val_d;
      sts_q        <= sts_d;
    end
  end

`ifndef SYNTHESIS
  a_hunt_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !collecting_q |-> (idx_q == 4'd0) && (xor_q == 8'h00) && hdr_ok_q)
    else $error("hunting with stale frame state");

  a_drop_noise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !collecting_q && (rx_byte_i != START_BYTE) |=> !collecting_q)
    else $error("non-start word opened a frame");

  a_end_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !collecting_q && (idx_q == 4'd0))
    else $error("frame not closed after checksum word");
`endif

endmodule

FILE: design/frc_out_reg.sv
module frc_out_reg
  import frc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  frc_result_t result_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output frc_result_t result_o,
  output logic        in_ready_o
);

  logic        valid_q, valid_d;
  frc_result_t data_q;

  // Take a new word whenever the held result leaves or none is held
  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign result_o    = data_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold payload until replaced
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !out_ready_i |-> !load_i)
    else $error("held result overwritten");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> valid_q && (data_q == $past(result_i)))
    else $error("loaded result not presented");

  a_stall_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !out_ready_i |=> valid_q && $stable(data_q))
    else $error("stalled result lost");
`endif

endmodule

FILE: design/fc_response_frame_checker_core.sv
// Channel   Dir  Payload                                      Handshake
// rx        in   rx_byte[7:0]                                 valid/ready
// res       out  frame_error[1:0] param_value[31:0]           valid/ready
//                stat_word[15:0]
// cfg       in   cfg_idx_i, cfg_wdata_i[11:0]                 cfg_we_i
//
// One word per cycle while rx.ready is high; a result is registered and appears
// in the cycle after the checksum word is accepted, and is held until res.ready.
// rx.ready drops only while a result is held and res.ready is low.
// Reset clears frame state and sets address 1, parameter number 0.
module fc_response_frame_checker_core
  import frc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  frc_rx_if.sink           rx,
  frc_res_if.source        res,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  logic [ADDR_W-1:0] dev_addr_q;
  logic [PNUM_W-1:0] param_num_q;
  logic              in_ready;
  logic              accept;
  logic              res_valid;
  frc_result_t       result;
  frc_result_t       res_data;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q  <= ADDR_W'(1);
      param_num_q <= '0;
    end else if (cfg_we_i) begin
      case (frc_cfg_e'(cfg_idx_i))
        CFG_DEV_ADDR:  dev_addr_q  <= cfg_wdata_i[ADDR_W-1:0];
        CFG_PARAM_NUM: param_num_q <= cfg_wdata_i[PNUM_W-1:0];
        default: ;
      endcase
    end
  end

  assign rx.ready = in_ready;
  assign accept   = rx.valid && in_ready;

  frc_tracker u_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx.rx_byte),
    .dev_addr_i  (dev_addr_q),
    .param_num_i (param_num_q),
    .res_valid_o (res_valid),
    .result_o    (result)
  );

  frc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .result_i    (result),
    .out_ready_i (res.ready),
    .out_valid_o (res.valid),
    .result_o    (res_data),
    .in_ready_o  (in_ready)
  );

  assign res.frame_error = res_data.frame_error;
  assign res.param_value = res_data.param_value;
  assign res.stat_word   = res_data.stat_word;

endmodule
